### src/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/maf_pkg.sv
`timescale 1ns / 1ps

package maf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COUNT_BITS = 24;

    localparam int EXTRA_BITS = 4;
    localparam int QBITS      = FRAC_BITS + EXTRA_BITS;
    localparam int IDX_BITS   = $clog2(QBITS);
    localparam int KT_BITS    = 31;
    localparam int OUT_CNT_BITS = 24;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TRIAL = 1'b1;

    localparam logic [1:0] CFG_KT_ENERGY  = 2'd0;
    localparam logic [1:0] CFG_STEP_LIMIT = 2'd1;

    typedef logic [30:0] exp_tab_t [QBITS];

    typedef struct packed {
        logic capture;
        logic eval;
        logic set_acc;
        logic clr_acc;
        logic div_init;
        logic div_step;
        logic mul_step;
        logic rnd_step;
        logic decide;
        logic commit;
    } maf_cmd_t;

    typedef struct packed {
        logic is_start;
        logic less;
        logic saturated;
        logic idx_last;
        logic out_free;
    } maf_status_t;

    // Restoring division used only while the table is built.
    function automatic longint unsigned div_small(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = (r << 1) | ((num >> b) & 64'd1);
            if (r >= den)
            begin
                r = r - den;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // exp(-2^e) in Q30 for the weight of each quotient bit.
    function automatic exp_tab_t build_exp_table();
        exp_tab_t tab;
        longint unsigned y;
        longint unsigned sum;
        longint unsigned term;
        int e;
        int eb;
        bit stop;
        for (int i = 0; i < QBITS; i++) begin
            e = i - FRAC_BITS;
            eb = (e > 0) ? 0 : e;
            y = longint'(1) << (30 + eb);
            sum = longint'(Q30_ONE);
            term = longint'(Q30_ONE);
            stop = 1'b0;
            for (int n = 1; n <= 24; n++) begin
                if (!stop) begin
                    term = div_small((term * y) >> 30, longint'(n));
                    if (term == 0) begin
                        stop = 1'b1;
                    end else if ((n & 1) == 1) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
            for (int k = 0; k < e; k++) begin
                sum = (sum * sum + (longint'(1) << 29)) >> 30;
            end
            tab[i] = sum[30:0];
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

### src/maf_ctrl.sv
`timescale 1ns / 1ps

module maf_ctrl import maf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  maf_status_t status,
    output maf_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_RND,
        ST_DECIDE,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (status.is_start || status.less)
                begin
                    cmd.set_acc = 1'b1;
                    state_next = ST_COMMIT;
                end
                else if (status.saturated)
                begin
                    cmd.clr_acc = 1'b1;
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                cmd.rnd_step = 1'b1;
                state_next = status.idx_last ? ST_DECIDE : ST_MUL;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/maf_datapath.sv
`timescale 1ns / 1ps

module maf_datapath import maf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  maf_cmd_t                 cmd,
    output maf_status_t              status,
    input  logic                     cfg_valid,
    input  logic [1:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     req_type,
    input  logic signed [31:0]       proposed_energy,
    input  logic [15:0]              random_uniform,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     accepted,
    output logic [OUT_CNT_BITS-1:0]  step_index,
    output logic signed [31:0]       reference_energy,
    output logic [OUT_CNT_BITS-1:0]  reject_count,
    output logic                     run_done
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [KT_BITS-1:0]      kt_reg;
    logic [23:0]             limit_reg;
    logic                    req_reg;
    logic signed [31:0]      prop_reg;
    logic [15:0]             rnd_reg;
    logic [32:0]             diff_reg;
    logic                    less_reg;
    logic [34:0]             kt12_reg;
    logic [KT_BITS-1:0]      rem_reg;
    logic [QBITS-1:0]        num_reg;
    logic [QBITS-1:0]        quot_reg;
    logic [IDX_BITS-1:0]     idx_reg;
    logic [30:0]             p_reg;
    logic [61:0]             prod_reg;
    logic                    acc_reg;
    logic signed [31:0]      ref_reg;
    logic [COUNT_BITS-1:0]   trial_reg;
    logic [COUNT_BITS-1:0]   rej_reg;
    logic                    out_valid_reg;
    logic                    out_acc_reg;
    logic [OUT_CNT_BITS-1:0] out_step_reg;
    logic signed [31:0]      out_ref_reg;
    logic [OUT_CNT_BITS-1:0] out_rej_reg;
    logic                    out_done_reg;

    logic [KT_BITS-1:0]      kt_eff;
    logic [32:0]             diff_next;
    logic [34:0]             kt_wide;
    logic [31:0]             r2;
    logic                    ge;
    logic [30:0]             factor;
    logic [16:0]             p16;
    logic [COUNT_BITS-1:0]   trial_next;
    logic [COUNT_BITS-1:0]   rej_next;
    logic                    idx_last;

    assign kt_eff    = (kt_reg == '0) ? KT_BITS'(1) : kt_reg;
    assign diff_next = {prop_reg[31], prop_reg} - {ref_reg[31], ref_reg};
    assign kt_wide   = {4'b0, kt_eff};
    assign r2        = {rem_reg, num_reg[QBITS-1]};
    assign ge        = (r2 >= {1'b0, kt_eff});
    assign factor    = quot_reg[idx_reg] ? EXP_TABLE[idx_reg] : Q30_ONE;
    assign p16       = 17'((p_reg + 31'(8192)) >> 14);
    assign idx_last  = (idx_reg == IDX_BITS'(QBITS - 1));
    assign trial_next = (trial_reg < COUNT_MAX) ? trial_reg + 1'b1 : trial_reg;
    assign rej_next  = (!acc_reg && rej_reg < COUNT_MAX) ? rej_reg + 1'b1 : rej_reg;

    assign status.is_start  = (req_reg == REQ_START);
    assign status.less      = less_reg;
    assign status.saturated = ({2'b0, diff_reg} >= kt12_reg);
    assign status.idx_last  = idx_last;
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kt_reg        <= KT_BITS'(39070);
            limit_reg     <= 24'd100;
            ref_reg       <= '0;
            trial_reg     <= '0;
            rej_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_KT_ENERGY)
                begin
                    kt_reg <= cfg_data[KT_BITS-1:0];
                end
                else if (cfg_index == CFG_STEP_LIMIT)
                begin
                    limit_reg <= cfg_data[23:0];
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (req_reg == REQ_START)
                begin
                    ref_reg   <= prop_reg;
                    trial_reg <= '0;
                    rej_reg   <= '0;
                end
                else
                begin
                    trial_reg <= trial_next;
                    rej_reg   <= rej_next;
                    if (acc_reg)
                    begin
                        ref_reg <= prop_reg;
                    end
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            prop_reg <= proposed_energy;
            rnd_reg  <= random_uniform;
        end
        if (cmd.eval)
        begin
            diff_reg <= diff_next;
            less_reg <= diff_next[32];
            kt12_reg <= (kt_wide << 3) + (kt_wide << 2);
        end
        if (cmd.set_acc)
        begin
            acc_reg <= 1'b1;
        end
        else if (cmd.clr_acc)
        begin
            acc_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            acc_reg <= (p16 > {1'b0, rnd_reg});
        end
        if (cmd.div_init)
        begin
            rem_reg  <= KT_BITS'(diff_reg >> EXTRA_BITS);
            num_reg  <= {diff_reg[EXTRA_BITS-1:0], {FRAC_BITS{1'b0}}};
            quot_reg <= '0;
            idx_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= ge ? KT_BITS'(r2 - {1'b0, kt_eff}) : r2[KT_BITS-1:0];
            num_reg  <= {num_reg[QBITS-2:0], 1'b0};
            quot_reg <= {quot_reg[QBITS-2:0], ge};
            if (idx_last)
            begin
                idx_reg <= '0;
                p_reg   <= Q30_ONE;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        else if (cmd.rnd_step)
        begin
            p_reg   <= 31'((prod_reg + 62'(1 << 29)) >> 30);
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= p_reg * factor;
        end
        if (cmd.commit)
        begin
            if (req_reg == REQ_START)
            begin
                out_acc_reg  <= 1'b1;
                out_step_reg <= '0;
                out_ref_reg  <= prop_reg;
                out_rej_reg  <= '0;
                out_done_reg <= 1'b0;
            end
            else
            begin
                out_acc_reg  <= acc_reg;
                out_step_reg <= OUT_CNT_BITS'(trial_next);
                out_ref_reg  <= acc_reg ? prop_reg : ref_reg;
                out_rej_reg  <= OUT_CNT_BITS'(rej_next);
                out_done_reg <= (32'(trial_next) == 32'(limit_reg));
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = out_acc_reg;
    assign step_index       = out_step_reg;
    assign reference_energy = out_ref_reg;
    assign reject_count     = out_rej_reg;
    assign run_done         = out_done_reg;

endmodule

### src/metropolis_acceptance_filter_core.sv
// A start item, or a downhill or hopeless trial, passes evaluate and check, then commits;
// any other trial first takes 20 restoring division steps, then 20 multiply and round pairs
// through one 31 by 31 multiplier and a decide step. One item is handled at a time: the
// next is taken only after the last is committed, and commit waits while results stall.
// Reset: asynchronous, active low; counters and reference energy clear, kT and limit
// return to their defaults.
`timescale 1ns / 1ps

module metropolis_acceptance_filter_core import maf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     req_type,
    input  logic signed [31:0]       proposed_energy,
    input  logic [15:0]              random_uniform,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     accepted,
    output logic [OUT_CNT_BITS-1:0]  step_index,
    output logic signed [31:0]       reference_energy,
    output logic [OUT_CNT_BITS-1:0]  reject_count,
    output logic                     run_done
);

`include "assert_macros.svh"

    maf_cmd_t    cmd;
    maf_status_t status;

    assign cfg_ready = 1'b1;

    maf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    maf_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_type         (req_type),
        .proposed_energy  (proposed_energy),
        .random_uniform   (random_uniform),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .accepted         (accepted),
        .step_index       (step_index),
        .reference_energy (reference_energy),
        .reject_count     (reject_count),
        .run_done         (run_done)
    );

    `ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "idle after transfer")
    `ASSERT_SAME(a_start_accepted, out_valid && step_index == '0, accepted && reject_count == '0 && !run_done, "start result malformed")
    `ASSERT_SAME(a_commit_free, cmd.commit, status.out_free, "result overwritten")
    `ASSERT_SAME(a_reject_bound, out_valid && !accepted, step_index != '0, "reject on start item")

endmodule

### sim/maf_checker.sv
`timescale 1ns / 1ps

module maf_checker import maf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    req_type,
    input  logic signed [31:0]      proposed_energy,
    input  logic [15:0]             random_uniform,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic                    accepted,
    input  logic [OUT_CNT_BITS-1:0] step_index,
    input  logic signed [31:0]      reference_energy,
    input  logic [OUT_CNT_BITS-1:0] reject_count,
    input  logic                    run_done,
    output int                      fail_count,
    output int                      pending
);

    typedef struct {
        logic              acc;
        logic [23:0]       step;
        logic signed [31:0] energy;
        logic [23:0]       rejects;
        logic              done;
    } decision_t;

    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 1;

    decision_t          decisions[$];
    longint unsigned    weight_tab[QBITS];
    logic [30:0]        kt_q;
    logic [23:0]        limit_q;
    logic signed [31:0] ref_energy;
    longint unsigned    trials;
    longint unsigned    rejects;

    function automatic longint unsigned exp_weight(int e);
        longint unsigned f;
        longint unsigned y;
        longint unsigned sum;
        longint unsigned term;
        if (e > 0) begin
            f = exp_weight(e - 1);
            return (f * f + (ONE_Q30 >> 1)) >> 30;
        end
        y = 64'd1 << (30 + e);
        sum = ONE_Q30;
        term = ONE_Q30;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * y) >> 30) / n;
            if (term == 0)
                break;
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    function automatic bit uphill_accept(longint unsigned diff, longint unsigned kt,
                                         logic [15:0] rnd);
        longint unsigned xq;
        longint unsigned p;
        if (diff >= 12 * kt)
            return 1'b0;
        xq = (diff << FRAC_BITS) / kt;
        p = ONE_Q30;
        for (int i = 0; i < QBITS; i++)
            if (xq[i])
                p = (p * weight_tab[i] + (ONE_Q30 >> 1)) >> 30;
        return ((p + (64'd1 << 13)) >> 14) > rnd;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch in %s: got %0d, expected %0d", field, got, want);
        fail_count++;
    endtask

    initial
    begin
        for (int i = 0; i < QBITS; i++)
            weight_tab[i] = exp_weight(i - FRAC_BITS);
    end

    assign pending = decisions.size();

    always @(posedge clk or negedge rst_n)
    begin
        decision_t d;
        decision_t w;
        longint    diff;
        if (!rst_n) begin
            kt_q = 31'd39070;
            limit_q = 24'd100;
            ref_energy = '0;
            trials = 0;
            rejects = 0;
            fail_count = 0;
            decisions.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_KT_ENERGY)
                    kt_q = cfg_data[30:0];
                else if (cfg_index == CFG_STEP_LIMIT)
                    limit_q = cfg_data[23:0];
            end
            if (in_valid && !in_stall) begin
                d.acc = 1'b1;
                d.done = 1'b0;
                if (req_type == REQ_START) begin
                    ref_energy = proposed_energy;
                    trials = 0;
                    rejects = 0;
                end else begin
                    if (trials < CNT_MAX)
                        trials++;
                    if (proposed_energy >= ref_energy) begin
                        diff = longint'(proposed_energy) - longint'(ref_energy);
                        d.acc = uphill_accept(diff, (kt_q == 0) ? 1 : kt_q, random_uniform);
                    end
                    if (d.acc)
                        ref_energy = proposed_energy;
                    else if (rejects < CNT_MAX)
                        rejects++;
                    d.done = (trials == limit_q);
                end
                d.step = trials[23:0];
                d.energy = ref_energy;
                d.rejects = rejects[23:0];
                decisions = {decisions, d};
            end
            if (out_valid && !out_stall) begin
                if (decisions.size() == 0) begin
                    $display("result transfer with no decision outstanding");
                    fail_count++;
                end else begin
                    w = decisions.pop_front();
                    if (accepted !== w.acc)
                        report("accepted", accepted, w.acc);
                    if (step_index !== w.step)
                        report("step_index", step_index, w.step);
                    if (reference_energy !== w.energy)
                        report("reference_energy", reference_energy, w.energy);
                    if (reject_count !== w.rejects)
                        report("reject_count", reject_count, w.rejects);
                    if (run_done !== w.done)
                        report("run_done", run_done, w.done);
                end
            end
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import maf_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [1:0]              cfg_index;
    logic [31:0]             cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    req_type;
    logic signed [31:0]      proposed_energy;
    logic [15:0]             random_uniform;
    logic                    out_valid;
    logic                    out_stall;
    logic                    accepted;
    logic [OUT_CNT_BITS-1:0] step_index;
    logic signed [31:0]      reference_energy;
    logic [OUT_CNT_BITS-1:0] reject_count;
    logic                    run_done;
    int                      fail_count;
    int                      pending;

    bit      quiet;
    int      idle_cycles;
    int      item_total;
    longint  kt_now;
    longint  base_energy;

    metropolis_acceptance_filter_core u_top (.*);

    maf_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap();
        if (quiet)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 3000) begin
            $display("metropolis_acceptance_filter_core test failed");
            $finish;
        end
    end

    initial
    begin
        int n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = draw_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send(logic rt, logic [31:0] pe, logic [15:0] ru);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type <= rt;
        proposed_energy <= pe;
        random_uniform <= ru;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        item_total++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (70) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        if (idx == CFG_KT_ENERGY)
            kt_now = (val[30:0] == 0) ? 1 : val[30:0];
    endtask

    function automatic logic [31:0] near_base();
        longint v;
        v = base_energy + ($signed($urandom_range(0, 8000)) - 4000) * kt_now / 1000;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic random_runs(int count);
        int k;
        k = 0;
        while (k < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send(1'($urandom_range(0, 1)), $urandom, 16'($urandom));
                k++;
            end else begin
                base_energy = $signed($urandom);
                if ($urandom_range(0, 3) == 0)
                    base_energy = base_energy / 65536;
                send(REQ_START, base_energy[31:0], 16'($urandom));
                k++;
                repeat ($urandom_range(1, 16)) begin
                    send(REQ_TRIAL, near_base(), 16'($urandom));
                    k++;
                end
            end
        end
    endtask

    initial
    begin
        logic [31:0] kt_set[6];
        logic [31:0] lim_set[6];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_START;
        proposed_energy = '0;
        random_uniform = '0;
        quiet = 1'b0;
        idle_cycles = 0;
        item_total = 0;
        kt_now = 39070;
        base_energy = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items under the reset configuration; the first is a trial before any start.
        send(REQ_TRIAL, 32'h0001_0000, 16'hFFFF);
        send(REQ_TRIAL, 32'h0001_0000, 16'h0000);
        send(REQ_START, 32'h0000_0000, 16'h1234);
        send(REQ_TRIAL, 32'h0000_0000, 16'hFFFF);
        send(REQ_TRIAL, 32'hFFFF_0000, 16'hFFFF);
        send(REQ_TRIAL, 32'h0000_9896, 16'h8000);
        send(REQ_TRIAL, 32'h0007_2716, 16'h0000);
        send(REQ_TRIAL, 32'h0007_2717, 16'h0000);
        send(REQ_START, 32'h8000_0000, 16'hFFFF);
        send(REQ_TRIAL, 32'h7FFF_FFFF, 16'h0000);
        send(REQ_TRIAL, 32'h8000_0000, 16'h0000);
        send(REQ_START, 32'h7FFF_FFFF, 16'h0000);
        send(REQ_TRIAL, 32'h8000_0000, 16'hFFFF);
        send(REQ_TRIAL, 32'h7FFF_FFFF, 16'hFFFF);
        drain();

        // Out-of-range indexes must leave both registers untouched.
        write_reg(2'd2, 32'hFFFF_FFFF);
        write_reg(2'd3, 32'h0000_0001);
        write_reg(CFG_STEP_LIMIT, 32'hFF00_0002);
        send(REQ_START, 32'h0000_0100, 16'h0);
        repeat (4) send(REQ_TRIAL, 32'h0000_0200, 16'h7FFF);
        drain();

        kt_set = '{32'd39070, 32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd65536, 32'd0};
        lim_set = '{32'd100, 32'd1, 32'hFF_FFFF, 32'd0, 32'd7, 32'd3};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_KT_ENERGY, kt_set[ph]);
            write_reg(CFG_STEP_LIMIT, lim_set[ph]);
            quiet = (ph == 2);
            random_runs(60);
            drain();
            random_runs(60);
            drain();
        end
        quiet = 1'b0;
        write_reg(CFG_KT_ENERGY, $urandom_range(1000, 400000));
        write_reg(CFG_STEP_LIMIT, $urandom_range(1, 12));
        random_runs(60);
        drain();

        $display("Sent %0d items across seven register settings, kT and step limit at both",
                 item_total);
        $display("extremes, with random gaps and stalls on both channels.");
        if (fail_count == 0 && pending == 0)
            $display("metropolis_acceptance_filter_core test passed");
        else
            $display("metropolis_acceptance_filter_core test failed");
        $finish;
    end

endmodule
